### rtl/cnv3_pkg.sv
package cnv3_pkg;

   localparam int MAX_WIDTH_DEF    = 1024;
   localparam int SAMPLE_BITS_DEF  = 16;
   localparam int KERNEL_ROWS      = 3;
   localparam int KERNEL_COLS      = 3;
   localparam int WEIGHT_BITS      = 16;
   localparam int KERNEL_REG_BITS  = 48;
   localparam int SAMPLE_PORT_BITS = 16;
   localparam int SUM_BITS         = 35;
   localparam int DIM_BITS         = 11;
   localparam int ROW_BITS         = 10;
   localparam int HEIGHT_CAP       = 1024;
   localparam int MIN_DIM          = 3;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int CSR_DATA_BITS    = 48;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_WIDTH   = 3'd0,
      CSR_FRAME_HEIGHT  = 3'd1,
      CSR_KERNEL_TOP    = 3'd2,
      CSR_KERNEL_MIDDLE = 3'd3,
      CSR_KERNEL_BOTTOM = 3'd4
   } csr_index_type;

   // marks that travel with a sample through the line stage
   typedef struct packed {
      logic emit;
      logic row_end;
      logic frame_end;
   } pos_flags_type;

   // window stage to multiply-accumulate stage
   typedef struct packed {
      logic valid;
      logic row_end;
      logic frame_end;
   } win_ctl_type;

endpackage

### rtl/cnv3_req_if.sv
interface cnv3_req_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [cnv3_pkg::SAMPLE_PORT_BITS-1:0] sample;
   logic                                      frame_start;

   modport source (output valid, output sample, output frame_start, input ready);
   modport sink (input valid, input sample, input frame_start, output ready);
endinterface

### rtl/cnv3_rsp_if.sv
interface cnv3_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [cnv3_pkg::SUM_BITS-1:0] window_sum;
   logic                                row_end;
   logic                                frame_end;

   modport source (output valid, output window_sum, output row_end, output frame_end,
                   input ready);
   modport sink (input valid, input window_sum, input row_end, input frame_end,
                 output ready);
endinterface

### rtl/cnv3_line_buf.sv
module cnv3_line_buf #(
   parameter int MAX_WIDTH   = cnv3_pkg::MAX_WIDTH_DEF,
   parameter int SAMPLE_BITS = cnv3_pkg::SAMPLE_BITS_DEF,
   localparam int CW = $clog2(MAX_WIDTH),
   localparam int LW = (CW + 1 > cnv3_pkg::DIM_BITS) ? CW + 1 : cnv3_pkg::DIM_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   cnv3_req_if.sink                        req,
   input  logic [LW-1:0]                   frame_width,
   input  logic [cnv3_pkg::DIM_BITS-1:0]   frame_height,
   output logic signed [SAMPLE_BITS-1:0]
                win [cnv3_pkg::KERNEL_ROWS][cnv3_pkg::KERNEL_COLS],
   output cnv3_pkg::win_ctl_type           win_ctl,
   input  logic                            mac_ready
);

   localparam int RB = cnv3_pkg::ROW_BITS;
   localparam int KR = cnv3_pkg::KERNEL_ROWS;
   localparam int KC = cnv3_pkg::KERNEL_COLS;

   // raster position
   logic [CW-1:0] col_ff, col_in, col_cur;
   logic [RB-1:0] row_ff, row_in, row_cur;
   logic          last_col, last_row, accept;
   cnv3_pkg::pos_flags_type flags_cur;

   // stage 1: sample waiting for its line store entry
   logic                          v1_ff;
   logic signed [SAMPLE_BITS-1:0] s1_ff;
   logic [CW-1:0]                 col1_ff;
   cnv3_pkg::pos_flags_type       flags1_ff;
   logic [2*SAMPLE_BITS-1:0]      rd_ff, byp_data_ff, line1, wr_data;
   logic                          byp_ff;

   // stage 2: window
   logic                          v2_ff;
   cnv3_pkg::pos_flags_type       flags2_ff;
   logic signed [SAMPLE_BITS-1:0] win_ff [KR][KC];

   logic acc1, acc2, mv2;

   // each entry holds {two rows up, one row up}
   logic [2*SAMPLE_BITS-1:0] line_mem [MAX_WIDTH];

   always_comb begin
      col_cur = req.frame_start ? '0 : col_ff;
      row_cur = req.frame_start ? '0 : row_ff;
      last_col = ({{(LW-CW){1'b0}}, col_cur} + LW'(1)) >= frame_width;
      last_row = ({1'b0, row_cur} + cnv3_pkg::DIM_BITS'(1)) >= frame_height;
      flags_cur.emit      = (row_cur >= RB'(2)) && (col_cur >= CW'(2));
      flags_cur.row_end   = last_col;
      flags_cur.frame_end = last_col && last_row;
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_cur + RB'(1);
      end else begin
         col_in = col_cur + CW'(1);
         row_in = row_cur;
      end
   end

   assign acc2      = !v2_ff || !flags2_ff.emit || mac_ready;
   assign acc1      = !v1_ff || acc2;
   assign mv2       = v1_ff && acc2;
   assign req.ready = !reset && acc1;
   assign accept    = req.valid && req.ready;

   assign line1   = byp_ff ? byp_data_ff : rd_ff;
   assign wr_data = {line1[SAMPLE_BITS-1:0], s1_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (acc1) begin
            v1_ff <= req.valid;
         end
         if (acc2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff       <= req.sample[SAMPLE_BITS-1:0];
         col1_ff     <= col_cur;
         flags1_ff   <= flags_cur;
         // same column as the write leaving stage 1 this cycle
         byp_ff      <= v1_ff && (col1_ff == col_cur);
         byp_data_ff <= wr_data;
      end
      if (mv2) begin
         flags2_ff <= flags1_ff;
         for (int r = 0; r < KR; r++) begin
            for (int c = 0; c < KC - 1; c++) begin
               win_ff[r][c] <= win_ff[r][c+1];
            end
         end
         win_ff[0][KC-1] <= line1[2*SAMPLE_BITS-1:SAMPLE_BITS];
         win_ff[1][KC-1] <= line1[SAMPLE_BITS-1:0];
         win_ff[2][KC-1] <= s1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= line_mem[col_cur];
      end
   end

   always_ff @(posedge clock) begin
      if (mv2) begin
         line_mem[col1_ff] <= wr_data;
      end
   end

   assign win               = win_ff;
   assign win_ctl.valid     = v2_ff && flags2_ff.emit;
   assign win_ctl.row_end   = flags2_ff.row_end;
   assign win_ctl.frame_end = flags2_ff.frame_end;

   a_frame_start_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req.frame_start |=> col_ff == CW'(1) && row_ff == '0)
      else $error("frame start did not restart the raster position");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> v1_ff && v2_ff && flags2_ff.emit && !mac_ready)
      else $error("input stalled with room in the line stage");

endmodule

### rtl/cnv3_mac.sv
module cnv3_mac #(
   parameter int SAMPLE_BITS = cnv3_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic signed [SAMPLE_BITS-1:0]
                win [cnv3_pkg::KERNEL_ROWS][cnv3_pkg::KERNEL_COLS],
   input  cnv3_pkg::win_ctl_type             win_ctl,
   output logic                              in_ready,
   input  logic [cnv3_pkg::KERNEL_REG_BITS-1:0] kernel [cnv3_pkg::KERNEL_ROWS],
   cnv3_rsp_if.source                        rsp
);

   localparam int KR  = cnv3_pkg::KERNEL_ROWS;
   localparam int KC  = cnv3_pkg::KERNEL_COLS;
   localparam int WB  = cnv3_pkg::WEIGHT_BITS;
   localparam int PW  = SAMPLE_BITS + WB;
   localparam int SB  = cnv3_pkg::SUM_BITS;

   logic                 v3_ff, v4_ff, rsp_valid_ff;
   logic                 row_end3_ff, frame_end3_ff, row_end4_ff, frame_end4_ff;
   logic                 row_end5_ff, frame_end5_ff;
   logic signed [PW-1:0] prod_ff [KR][KC];
   logic signed [SB-1:0] rsum_ff [KR];
   logic signed [SB-1:0] sum_ff;
   logic                 acc3, acc4, acc5;

   assign acc5     = !rsp_valid_ff || rsp.ready;
   assign acc4     = !v4_ff || acc5;
   assign acc3     = !v3_ff || acc4;
   assign in_ready = acc3;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (acc3) begin
            v3_ff <= win_ctl.valid;
         end
         if (acc4) begin
            v4_ff <= v3_ff;
         end
         if (acc5) begin
            rsp_valid_ff <= v4_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc3) begin
         row_end3_ff   <= win_ctl.row_end;
         frame_end3_ff <= win_ctl.frame_end;
         for (int r = 0; r < KR; r++) begin
            for (int c = 0; c < KC; c++) begin
               prod_ff[r][c] <= $signed(kernel[r][c*WB +: WB]) * win[r][c];
            end
         end
      end
      if (acc4) begin
         row_end4_ff   <= row_end3_ff;
         frame_end4_ff <= frame_end3_ff;
         for (int r = 0; r < KR; r++) begin
            rsum_ff[r] <= {{(SB-PW){prod_ff[r][0][PW-1]}}, prod_ff[r][0]}
                        + {{(SB-PW){prod_ff[r][1][PW-1]}}, prod_ff[r][1]}
                        + {{(SB-PW){prod_ff[r][2][PW-1]}}, prod_ff[r][2]};
         end
      end
      if (acc5) begin
         row_end5_ff   <= row_end4_ff;
         frame_end5_ff <= frame_end4_ff;
         sum_ff        <= rsum_ff[0] + rsum_ff[1] + rsum_ff[2];
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.window_sum = sum_ff;
   assign rsp.row_end    = row_end5_ff;
   assign rsp.frame_end  = frame_end5_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> v3_ff && v4_ff && rsp_valid_ff && !rsp.ready)
      else $error("window stage stalled with a free stage downstream");

   a_frame_end_ends_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && frame_end5_ff |-> row_end5_ff)
      else $error("frame end without row end");

endmodule

### rtl/valid_2d_convolution_3x3_core.sv
// channel  ports             direction  payload
// req      req.valid/ready   in         sample (16b signed), frame_start
// rsp      rsp.valid/ready   out        window_sum (35b signed), row_end, frame_end
// csr      csr_write_en      in         csr_index (3b), csr_data (48b), write only
//
// one sample per clock sustained while rsp is not stalled
// throughput set by the line store: one read port and one write port, each used once a clock
// reset is synchronous, active high; the line store has no reset and needs no clearing
// a stalled rsp fills the pipe, then req.ready drops; bubbles collapse on the way
// a frame of W x H samples gives (W-2) x (H-2) results
module valid_2d_convolution_3x3_core #(
   parameter int MAX_WIDTH   = cnv3_pkg::MAX_WIDTH_DEF,
   parameter int SAMPLE_BITS = cnv3_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   cnv3_req_if.sink                             req,
   cnv3_rsp_if.source                           rsp,
   input  logic                                 csr_write_en,
   input  logic [cnv3_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [cnv3_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int LW = (CW + 1 > cnv3_pkg::DIM_BITS) ? CW + 1 : cnv3_pkg::DIM_BITS;
   localparam int DB = cnv3_pkg::DIM_BITS;
   localparam int KB = cnv3_pkg::KERNEL_REG_BITS;
   localparam int KR = cnv3_pkg::KERNEL_ROWS;
   localparam int KC = cnv3_pkg::KERNEL_COLS;
   localparam int WIDTH_RESET = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

   // sizes are stored already clamped to their usable range
   logic [LW-1:0] width_ff, width_in;
   logic [DB-1:0] height_ff, height_in;
   logic [KB-1:0] kernel_ff [KR];
   logic [DB-1:0] wr_dim;

   logic signed [SAMPLE_BITS-1:0] win [KR][KC];
   cnv3_pkg::win_ctl_type         win_ctl;
   logic                          mac_ready;

   // clamp of the written size value
   always_comb begin
      wr_dim = csr_data[DB-1:0];
      if (wr_dim < DB'(cnv3_pkg::MIN_DIM)) begin
         width_in  = LW'(cnv3_pkg::MIN_DIM);
         height_in = DB'(cnv3_pkg::MIN_DIM);
      end else begin
         width_in  = (LW'(wr_dim) > LW'(MAX_WIDTH)) ? LW'(MAX_WIDTH) : LW'(wr_dim);
         height_in = (wr_dim > DB'(cnv3_pkg::HEIGHT_CAP)) ? DB'(cnv3_pkg::HEIGHT_CAP)
                   : wr_dim;
      end
   end

   // register file; write only while no transaction is in flight, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= LW'(WIDTH_RESET);
         height_ff <= DB'(cnv3_pkg::HEIGHT_CAP);
         for (int r = 0; r < KR; r++) begin
            kernel_ff[r] <= '0;
         end
      end else if (csr_write_en) begin
         unique case (csr_index)
            cnv3_pkg::CSR_FRAME_WIDTH:   width_ff     <= width_in;
            cnv3_pkg::CSR_FRAME_HEIGHT:  height_ff    <= height_in;
            cnv3_pkg::CSR_KERNEL_TOP:    kernel_ff[0] <= csr_data[KB-1:0];
            cnv3_pkg::CSR_KERNEL_MIDDLE: kernel_ff[1] <= csr_data[KB-1:0];
            cnv3_pkg::CSR_KERNEL_BOTTOM: kernel_ff[2] <= csr_data[KB-1:0];
            default: ;
         endcase
      end
   end

   // counters, line store and 3x3 window
   cnv3_line_buf #(
      .MAX_WIDTH   (MAX_WIDTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_line_buf (
      .clock        (clock),
      .reset        (reset),
      .req          (req),
      .frame_width  (width_ff),
      .frame_height (height_ff),
      .win          (win),
      .win_ctl      (win_ctl),
      .mac_ready    (mac_ready)
   );

   // products, row sums, output register
   cnv3_mac #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .win      (win),
      .win_ctl  (win_ctl),
      .in_ready (mac_ready),
      .kernel   (kernel_ff),
      .rsp      (rsp)
   );

   a_width_in_range: assert property (@(posedge clock) disable iff (reset)
      width_ff >= LW'(cnv3_pkg::MIN_DIM) && width_ff <= LW'(MAX_WIDTH))
      else $error("stored frame width out of range");

   a_height_in_range: assert property (@(posedge clock) disable iff (reset)
      height_ff >= DB'(cnv3_pkg::MIN_DIM) && height_ff <= DB'(cnv3_pkg::HEIGHT_CAP))
      else $error("stored frame height out of range");

endmodule
